>>> rtl/frpm_pkg.sv
// Shared constants and types for the frame RMS and peak level meter.
`timescale 1ns / 1ps
`default_nettype none

package frpm_pkg;

    // Widths fixed by the channel payloads
    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 16;
    localparam int CFG_W    = 13;

    // Defaults and reset values
    localparam int               MAX_FRAME_DEF      = 4096;
    localparam logic [CFG_W-1:0] FRAME_LENGTH_RESET = 13'd512;

    // Frame queue between the accumulator and the level engine
    localparam int QUEUE_DEPTH = 4;

    // Level engine sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_HOLD
    } t_back_state;

endpackage

`default_nettype wire

>>> rtl/frpm_if.sv
// Channel interfaces: sample requests, result requests and the length write port.
`timescale 1ns / 1ps
`default_nettype none

interface frpm_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [frpm_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface frpm_result_if;
    logic                         valid;
    logic                         ready;
    logic [frpm_pkg::LEVEL_W-1:0] peak_level;
    logic [frpm_pkg::LEVEL_W-1:0] rms_level;

    modport source (output valid, output peak_level, output rms_level, input ready);
    modport sink   (input valid, input peak_level, input rms_level, output ready);
endinterface

interface frpm_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [frpm_pkg::CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/frpm_front.sv
// Front end: takes samples, keeps per-frame peak and sum of squares, hands off frames.
`timescale 1ns / 1ps
`default_nettype none

module frpm_front #(
    parameter int MAX_FRAME = frpm_pkg::MAX_FRAME_DEF,
    localparam int LEN_W    = $clog2(MAX_FRAME + 1),
    localparam int SUM_W    = 31 + $clog2(MAX_FRAME),
    localparam int FRAME_W  = SUM_W + frpm_pkg::LEVEL_W + LEN_W
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_valid,
    input  wire logic [frpm_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic signed [frpm_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                                 i_room,
    output logic                                      o_push,
    output logic [FRAME_W-1:0]                        o_push_data
);

    localparam int LV = frpm_pkg::LEVEL_W;

    logic [frpm_pkg::CFG_W-1:0] r_len;
    logic [LEN_W-1:0]           eff_len;
    logic [LEN_W-1:0]           r_count;
    logic [LV-1:0]              r_peak;
    logic [SUM_W-1:0]           r_sum;
    logic                       r_st_valid;
    logic                       r_st_last;
    logic [31:0]                r_sq;
    logic [LV-1:0]              r_fpeak;
    logic [LEN_W-1:0]           r_flen;

    logic [16:0]      mag17;
    logic [LV-1:0]    mag;
    logic [LV-1:0]    new_peak;
    logic             accept;
    logic             last;
    logic [SUM_W-1:0] sum_next;

    // Hold the frame length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= frpm_pkg::FRAME_LENGTH_RESET;
        end else if (i_cfg_valid) begin
            r_len <= i_cfg_data;
        end
    end

    // Clamp the length: zero means one, above the maximum saturates
    always_comb begin
        if (32'(r_len) > 32'(MAX_FRAME)) begin
            eff_len = LEN_W'(MAX_FRAME);
        end else if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else begin
            eff_len = LEN_W'(r_len);
        end
    end

    // Magnitude; the most negative sample gives 32768
    assign mag17    = i_sample[15] ? (17'h10000 - {1'b0, i_sample}) : {1'b0, i_sample};
    assign mag      = mag17[LV-1:0];
    assign new_peak = (mag > r_peak) ? mag : r_peak;

    // Take a sample only while the queue can absorb a frame in flight
    assign o_ready = i_room;
    assign accept  = i_valid & o_ready;
    assign last    = ((LEN_W+1)'(r_count) + (LEN_W+1)'(1)) >= (LEN_W+1)'(eff_len);

    // Advance count and peak at accept, square the magnitude into the stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_peak     <= '0;
            r_st_valid <= 1'b0;
        end else begin
            r_st_valid <= accept;
            if (accept) begin
                r_count <= last ? '0 : r_count + LEN_W'(1);
                r_peak  <= last ? '0 : new_peak;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_st_last <= last;
            r_sq      <= 32'(mag) * 32'(mag);
            r_fpeak   <= new_peak;
            r_flen    <= eff_len;
        end
    end

    // Accumulate the square; drop the sum after the frame is handed off
    assign sum_next = r_sum + SUM_W'(r_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (r_st_valid) begin
            r_sum <= r_st_last ? '0 : sum_next;
        end
    end

    assign o_push      = r_st_valid & r_st_last;
    assign o_push_data = {sum_next, r_fpeak, r_flen};

endmodule

`default_nettype wire

>>> rtl/frpm_queue.sv
// Short frame queue between the accumulator and the level engine.
`timescale 1ns / 1ps
`default_nettype none

module frpm_queue #(
    parameter int WIDTH = 8,
    localparam int DEPTH = frpm_pkg::QUEUE_DEPTH,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_room,
    output logic                  o_valid,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    // Keep two free entries: one for the frame in flight, one for the next
    assign o_room  = r_count <= CNT_W'(DEPTH - 2);
    assign o_valid = r_count != '0;
    assign do_pop  = i_pop & o_valid;
    assign o_data  = r_rd_data;

    assign n_rd_ptr = !do_pop ? r_rd_ptr :
                      (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);

    // Write the entry; keep the head entry registered, bypassing a write to it
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (i_push && r_wr_ptr == n_rd_ptr) begin
            r_rd_data <= i_data;
        end else begin
            r_rd_data <= r_mem[n_rd_ptr];
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            r_rd_ptr <= n_rd_ptr;
            if (i_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/frpm_back.sv
// Back end: divides the frame sum by its length, takes the root, registers the result.
`timescale 1ns / 1ps
`default_nettype none

module frpm_back #(
    parameter int MAX_FRAME = frpm_pkg::MAX_FRAME_DEF,
    localparam int LEN_W    = $clog2(MAX_FRAME + 1),
    localparam int SUM_W    = 31 + $clog2(MAX_FRAME),
    localparam int FRAME_W  = SUM_W + frpm_pkg::LEVEL_W + LEN_W,
    localparam int DCNT_W   = $clog2(SUM_W)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_pop,
    input  wire logic [FRAME_W-1:0]            i_data,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [frpm_pkg::LEVEL_W-1:0]       o_peak_level,
    output logic [frpm_pkg::LEVEL_W-1:0]       o_rms_level
);

    localparam int LV       = frpm_pkg::LEVEL_W;
    // Root datapath: the quotient can use the full sum width
    localparam int RW       = SUM_W + 1;
    localparam int RT_STEPS = (SUM_W + 1) / 2;
    localparam int KW       = $clog2(RT_STEPS);

    frpm_pkg::t_back_state r_state, n_state;

    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [LEN_W-1:0]  r_rem, n_rem;
    logic [LEN_W-1:0]  r_div, n_div;
    logic [LV-1:0]     r_peak, n_peak;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;
    logic [SUM_W-1:0]  r_v, n_v;
    logic [RW-1:0]     r_root, n_root;
    logic [KW-1:0]     r_k, n_k;
    logic              r_out_valid, n_out_valid;
    logic [LV-1:0]     r_out_peak, n_out_peak;
    logic [LV-1:0]     r_out_rms, n_out_rms;

    logic [LEN_W:0]    trial;
    logic [LEN_W:0]    diff;
    logic              ge;
    logic [RW-1:0]     bitv;
    logic [RW-1:0]     rb;

    // State register and control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= frpm_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_peak     <= n_peak;
        r_dcnt     <= n_dcnt;
        r_v        <= n_v;
        r_root     <= n_root;
        r_k        <= n_k;
        r_out_peak <= n_out_peak;
        r_out_rms  <= n_out_rms;
    end

    // One restoring divide step and one root digit step
    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = trial >= {1'b0, r_div};
    assign bitv  = RW'(1) << {r_k, 1'b0};
    assign rb    = r_root + bitv;

    always_comb begin
        n_state     = r_state;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_div       = r_div;
        n_peak      = r_peak;
        n_dcnt      = r_dcnt;
        n_v         = r_v;
        n_root      = r_root;
        n_k         = r_k;
        n_out_peak  = r_out_peak;
        n_out_rms   = r_out_rms;
        n_out_valid = r_out_valid & ~i_ready;
        o_pop       = 1'b0;

        case (r_state)
            frpm_pkg::ST_IDLE: begin
                // Pull the next finished frame
                o_pop = i_valid;
                if (i_valid) begin
                    n_quo   = i_data[FRAME_W-1 -: SUM_W];
                    n_peak  = i_data[LEN_W +: LV];
                    n_div   = i_data[LEN_W-1:0];
                    n_rem   = '0;
                    n_dcnt  = DCNT_W'(SUM_W - 1);
                    n_state = frpm_pkg::ST_DIV;
                end
            end
            frpm_pkg::ST_DIV: begin
                n_rem = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
                n_quo = {r_quo[SUM_W-2:0], ge};
                n_dcnt = r_dcnt - DCNT_W'(1);
                if (r_dcnt == '0) begin
                    // A length shrunk mid-frame can push the mean square past 2^30
                    n_v     = n_quo;
                    n_root  = '0;
                    n_k     = KW'(RT_STEPS - 1);
                    n_state = frpm_pkg::ST_SQRT;
                end
            end
            frpm_pkg::ST_SQRT: begin
                if ({1'b0, r_v} >= rb) begin
                    n_v    = r_v - rb[SUM_W-1:0];
                    n_root = (r_root >> 1) + bitv;
                end else begin
                    n_root = r_root >> 1;
                end
                n_k = r_k - KW'(1);
                if (r_k == '0) begin
                    n_state = frpm_pkg::ST_HOLD;
                end
            end
            frpm_pkg::ST_HOLD: begin
                // Load the output register once it is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_peak  = r_peak;
                    n_out_rms   = r_root[LV-1:0];
                    n_state     = frpm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = frpm_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_peak_level = r_out_peak;
    assign o_rms_level  = r_out_rms;

endmodule

`default_nettype wire

>>> rtl/frame_rms_peak_meter.sv
// Top level of the frame RMS and peak level meter.
//
//  channel    dir  handshake      request contents
//  i_sample   in   valid/ready    sample (s16)
//  o_result   out  valid/ready    peak_level (u16), rms_level (u16)
//  i_cfg      in   valid/ready    data: frame_length (u13), ready tied high
//
// Samples are taken one per cycle while the frame queue has two free entries.
// The level engine takes one frame at a time: a one-bit-per-cycle restoring divider
// followed by a one-digit-per-cycle root.
// Reset is synchronous: accumulators clear, frame_length returns to 512; no clearing pass.
// A stalled result holds in the output register; once three finished frames wait
// in the queue the sample side stalls, and the fourth entry takes the frame still
// being squared.
`timescale 1ns / 1ps
`default_nettype none

module frame_rms_peak_meter #(
    parameter int MAX_FRAME = frpm_pkg::MAX_FRAME_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    frpm_sample_if.sink    i_sample,
    frpm_result_if.source  o_result,
    frpm_cfg_if.sink       i_cfg
);

    localparam int LEN_W   = $clog2(MAX_FRAME + 1);
    localparam int SUM_W   = 31 + $clog2(MAX_FRAME);
    localparam int FRAME_W = SUM_W + frpm_pkg::LEVEL_W + LEN_W;

    logic               room;
    logic               push;
    logic [FRAME_W-1:0] push_data;
    logic               q_valid;
    logic               q_pop;
    logic [FRAME_W-1:0] q_data;

    // Length writes are always taken
    assign i_cfg.ready = 1'b1;

    frpm_front #(
        .MAX_FRAME(MAX_FRAME)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .i_valid     (i_sample.valid),
        .o_ready     (i_sample.ready),
        .i_sample    (i_sample.sample),
        .i_room      (room),
        .o_push      (push),
        .o_push_data (push_data)
    );

    frpm_queue #(
        .WIDTH(FRAME_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_room  (room),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    frpm_back #(
        .MAX_FRAME(MAX_FRAME)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .o_pop        (q_pop),
        .i_data       (q_data),
        .o_valid      (o_result.valid),
        .i_ready      (o_result.ready),
        .o_peak_level (o_result.peak_level),
        .o_rms_level  (o_result.rms_level)
    );

endmodule

`default_nettype wire

>>> rtl/frpm_chk.sv
// Port-level checks on the meter's result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module frpm_chk (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [frpm_pkg::LEVEL_W-1:0] i_peak_level,
    input wire logic [frpm_pkg::LEVEL_W-1:0] i_rms_level
);

    // A pending result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A pending result keeps its levels until taken
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_peak_level) && $stable(i_rms_level))
        else $error("result changed while stalled");

    // Peak magnitude is bounded by the most negative sample
    a_peak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_peak_level <= 16'd32768)
        else $error("peak level out of range");

    // Reset clears the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind frame_rms_peak_meter frpm_chk u_frpm_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_peak_level (o_result.peak_level),
    .i_rms_level  (o_result.rms_level)
);

`default_nettype wire

>>> tb/frame_rms_peak_meter_tb.sv
// Self-checking testbench for the frame RMS and peak level meter.
`timescale 1ns / 1ps

module frame_rms_peak_meter_tb;

    localparam int HALF_PERIOD       = 4;
    localparam int RESET_CYCLES      = 12;
    localparam int SETTLE_CYCLES     = 80;
    localparam int END_SETTLE_CYCLES = 150;
    localparam int RESULT_HOLD       = 500;
    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int RANDOM_ITEMS      = 300;

    typedef struct packed {
        logic [frpm_pkg::LEVEL_W-1:0] peak;
        logic [frpm_pkg::LEVEL_W-1:0] rms;
    } t_frame_levels;

    // Predicts the levels of each finished frame and checks the results against them
    class t_level_scoreboard;
        logic [frpm_pkg::CFG_W-1:0] frame_length;
        longint unsigned            square_sum;
        logic [16:0]                running_peak;
        int unsigned                samples_seen;
        t_frame_levels              expected_levels[$];
        int                         errors;
        int                         frames_checked;

        function new();
            frame_length   = frpm_pkg::FRAME_LENGTH_RESET;
            square_sum     = 0;
            running_peak   = '0;
            samples_seen   = 0;
            errors         = 0;
            frames_checked = 0;
        endfunction

        function logic [frpm_pkg::LEVEL_W-1:0] floor_root(input longint unsigned v);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            // Build the root one bit at a time from the top
            for (int b = 21; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= v) begin
                    root = trial;
                end
            end
            return root[frpm_pkg::LEVEL_W-1:0];
        endfunction

        function void set_length(input logic [frpm_pkg::CFG_W-1:0] value);
            frame_length = value;
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction

        function void note_sample(input logic signed [frpm_pkg::SAMPLE_W-1:0] s);
            int            value;
            int unsigned   mag;
            int unsigned   len;
            t_frame_levels lv;
            value = s;
            mag = (value < 0) ? -value : value;
            if (mag > running_peak) begin
                running_peak = mag[16:0];
            end
            square_sum += longint'(mag) * longint'(mag);
            samples_seen++;
            // Zero length acts as one, anything past the frame limit saturates
            len = frame_length;
            if (len == 0) begin
                len = 1;
            end
            if (len > frpm_pkg::MAX_FRAME_DEF) begin
                len = frpm_pkg::MAX_FRAME_DEF;
            end
            if (samples_seen < len) begin
                return;
            end
            lv.peak = running_peak[frpm_pkg::LEVEL_W-1:0];
            lv.rms  = floor_root(square_sum / len);
            expected_levels.push_back(lv);
            square_sum   = 0;
            running_peak = '0;
            samples_seen = 0;
        endfunction

        task report_mismatch(input string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_levels(input logic [frpm_pkg::LEVEL_W-1:0] peak,
                          input logic [frpm_pkg::LEVEL_W-1:0] rms);
            t_frame_levels want;
            if (expected_levels.size() == 0) begin
                report_mismatch($sformatf("unexpected result peak=%0d rms=%0d", peak, rms));
                return;
            end
            want = expected_levels.pop_front();
            frames_checked++;
            if (peak !== want.peak) begin
                report_mismatch($sformatf("frame %0d peak_level got %0d want %0d",
                                          frames_checked, peak, want.peak));
            end
            if (rms !== want.rms) begin
                report_mismatch($sformatf("frame %0d rms_level got %0d want %0d",
                                          frames_checked, rms, want.rms));
            end
        endtask

        task check_drained();
            while (expected_levels.size() != 0) begin
                void'(expected_levels.pop_front());
                report_mismatch("expected frame result never arrived");
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    frpm_sample_if smp();
    frpm_result_if res();
    frpm_cfg_if    cfg();

    t_level_scoreboard sb = new();

    bit sender_steady;
    bit receiver_steady;
    bit hold_results;
    int quiet_cycles;

    frame_rms_peak_meter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp),
        .o_result (res),
        .i_cfg    (cfg)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    function automatic logic signed [frpm_pkg::SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                case ($urandom_range(0, 4))
                    0: return -16'sd32768;
                    1: return 16'sd32767;
                    2: return 16'sd0;
                    3: return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
            1, 2, 3, 4: return 16'($urandom);
            5, 6, 7: return 16'($urandom_range(0, 511)) - 16'sd256;
            default: begin
                if ($urandom_range(0, 1) == 1) begin
                    return 16'($urandom_range(30000, 32767));
                end
                return -16'($urandom_range(30000, 32768));
            end
        endcase
    endfunction

    // Offer one sample request and hold it until the block takes it
    task automatic send_sample(input logic signed [frpm_pkg::SAMPLE_W-1:0] s);
        int gap;
        gap = pick_gap(sender_steady);
        if (gap > 0) begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp.valid  <= 1'b1;
        smp.sample <= s;
        do @(posedge i_clk); while (smp.ready !== 1'b1);
        sb.note_sample(s);
    endtask

    // Drop the sample request and wait for every pending frame result
    task automatic wait_drained();
        smp.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic wait_idle(input int settle);
        wait_drained();
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [frpm_pkg::CFG_W-1:0] len);
        cfg.valid <= 1'b1;
        cfg.data  <= len;
        do @(posedge i_clk); while (cfg.ready !== 1'b1);
        sb.set_length(len);
        cfg.valid <= 1'b0;
    endtask

    // Result side: random ready gaps, plus one long hold on request
    initial begin
        int gap;
        res.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_results) begin
                res.ready <= 1'b0;
                repeat (RESULT_HOLD) @(posedge i_clk);
                hold_results = 1'b0;
            end else begin
                gap = pick_gap(receiver_steady);
                if (gap > 0) begin
                    res.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                res.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Check every accepted result request
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1) begin
            sb.check_levels(res.peak_level, res.rms_level);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((smp.valid === 1'b1 && smp.ready === 1'b1) ||
            (res.valid === 1'b1 && res.ready === 1'b1) ||
            (cfg.valid === 1'b1 && cfg.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("frame_rms_peak_meter_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic signed [frpm_pkg::SAMPLE_W-1:0] edge_samples[$];
        logic [frpm_pkg::CFG_W-1:0]           len;
        int                                   random_sent;
        int                                   count;
        int                                   pause_at;
        int                                   pick;

        i_rst_n         = 1'b0;
        smp.valid       = 1'b0;
        smp.sample      = '0;
        cfg.valid       = 1'b0;
        cfg.data        = '0;
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        hold_results    = 1'b0;
        quiet_cycles    = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset length keeps the frame open; a length of one closes it next
        repeat (20) send_sample(pick_sample());
        wait_idle(SETTLE_CYCLES);
        write_length(13'd1);
        send_sample(pick_sample());
        wait_idle(SETTLE_CYCLES);

        // Zero length acts as one: every sample closes a frame
        write_length('0);
        edge_samples = '{16'sd0, 16'sd32767, -16'sd32768, -16'sd1, 16'sd1,
                         16'sh5555, -16'sh5556, -16'sd32767, 16'sd2};
        foreach (edge_samples[i]) begin
            send_sample(edge_samples[i]);
        end
        wait_idle(SETTLE_CYCLES);

        write_length(13'd2);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        wait_idle(SETTLE_CYCLES);

        // Shrink the length mid-frame: the frame closes on the next sample
        write_length(13'd3);
        send_sample(16'sd1000);
        send_sample(-16'sd2000);
        wait_idle(SETTLE_CYCLES);
        write_length(13'd2);
        send_sample(16'sd3000);
        wait_idle(SETTLE_CYCLES);

        // Grow the length mid-frame: the partial sums carry over
        write_length(13'd5);
        send_sample(-16'sd7);
        send_sample(16'sd12345);
        wait_idle(SETTLE_CYCLES);
        write_length(13'd8);
        repeat (6) send_sample(pick_sample());
        wait_idle(SETTLE_CYCLES);

        // Length above the frame limit saturates and holds the frame open;
        // closing it at length one gives a mean square far past 2^30
        sender_steady = 1'b1;
        write_length(13'h1FFF);
        repeat (30) send_sample(-16'sd32768);
        wait_idle(SETTLE_CYCLES);
        write_length(13'd1);
        send_sample(-16'sd32768);
        wait_idle(SETTLE_CYCLES);
        sender_steady = 1'b0;

        // Hold the result side off while samples keep coming, to fill the queue
        write_length(13'd1);
        hold_results = 1'b1;
        repeat (40) send_sample(pick_sample());
        wait_idle(SETTLE_CYCLES);

        // Random phases, mostly short frames
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                len = '0;
            end else if (pick == 1) begin
                len = 13'($urandom_range(17, 64));
            end else if (pick == 2) begin
                len = 13'd1;
            end else begin
                len = 13'($urandom_range(2, 16));
            end
            write_length(len);
            sender_steady   = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
            count    = $urandom_range(10, 60);
            pause_at = ($urandom_range(0, 3) == 0) ? count / 2 : -1;
            for (int k = 0; k < count; k++) begin
                if (k == pause_at) begin
                    wait_drained();
                end
                send_sample(pick_sample());
            end
            random_sent += count;
            wait_idle(SETTLE_CYCLES);
        end

        wait_idle(END_SETTLE_CYCLES);
        sb.check_drained();
        if (sb.errors == 0) begin
            $display("frame_rms_peak_meter_tb: PASS");
        end else begin
            $display("frame_rms_peak_meter_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/frpm_pkg.sv
rtl/frpm_if.sv
rtl/frpm_front.sv
rtl/frpm_queue.sv
rtl/frpm_back.sv
rtl/frame_rms_peak_meter.sv
rtl/frpm_chk.sv
tb/frame_rms_peak_meter_tb.sv
